@@ rtl/fcs_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// fcs_pkg - shared definitions for the format comment stripper
// Character codes, result and push bundles, and default sizes.
// ============================================================================
package fcs_pkg;

    localparam int CHAR_W              = 16;
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    // Configuration register indexes and APB address width.
    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;
    localparam logic [0:0] REG_STRIP_CONTROLS = 1'b0;

    localparam logic [CHAR_W-1:0] CH_SLASH  = 16'h002F;
    localparam logic [CHAR_W-1:0] CH_STAR   = 16'h002A;
    localparam logic [CHAR_W-1:0] CH_APOS   = 16'h0027;
    localparam logic [CHAR_W-1:0] CH_DQUOTE = 16'h0022;
    localparam logic [CHAR_W-1:0] CH_BAR    = 16'h007C;
    localparam logic [CHAR_W-1:0] CH_CR     = 16'h000D;
    localparam logic [CHAR_W-1:0] CH_LF     = 16'h000A;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 16'h0020;
    localparam logic [CHAR_W-1:0] CH_NULL   = 16'h0000;

    // One accepted input character.
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } item_t;

    // One result transaction.
    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic              has_char;
        logic              end_of_text;
    } res_t;

    // Up to two results produced by one character, in order.
    typedef struct packed {
        logic [1:0] count;
        res_t       first;
        res_t       second;
    } push_t;

endpackage

@@ rtl/fcs_in_stage.sv @@
`timescale 1ns / 1ps
// ============================================================================
// fcs_in_stage - input register
// Holds one accepted character until the scanner consumes it.
// ============================================================================
module fcs_in_stage
    import fcs_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  item_t             s_item,
    input  logic              take,
    output logic              item_valid,
    output item_t             item
);

    logic  valid_reg;
    item_t item_reg;

    // A new character may enter when the register is empty or drains this cycle.
    assign s_ready    = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            item_reg <= s_item;
        end
    end

endmodule

@@ rtl/fcs_scan.sv @@
`timescale 1ns / 1ps
// ============================================================================
// fcs_scan - comment and quote scanner
// Tracks quote, comment and held-slash state and forms up to two results.
// ============================================================================
module fcs_scan
    import fcs_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  strip_controls,
    input  logic  item_valid,
    input  item_t item,
    input  logic  room,
    output logic  take,
    output push_t push
);

    typedef enum logic [1:0] {
        MODE_PLAIN   = 2'd0,
        MODE_QUOTE   = 2'd1,
        MODE_COMMENT = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        QK_NONE   = 2'd0,
        QK_APOS   = 2'd1,
        QK_DQUOTE = 2'd2,
        QK_BAR    = 2'd3
    } quote_t;

    mode_t  mode_reg,    mode_next;
    quote_t quote_reg,   quote_next;
    logic   pending_reg, pending_next;

    quote_t qc;
    logic   plain_path;
    logic   en_held, en_char, en_char_kept, en_tail;
    logic   is_control;
    logic [1:0] n_res;
    res_t   r0, r1;

    assign take = item_valid && room;

    always_comb begin
        if (item.ch == CH_APOS) begin
            qc = QK_APOS;
        end else if (item.ch == CH_DQUOTE) begin
            qc = QK_DQUOTE;
        end else if (item.ch == CH_BAR) begin
            qc = QK_BAR;
        end else begin
            qc = QK_NONE;
        end
    end

    always_comb begin
        mode_next    = mode_reg;
        quote_next   = quote_reg;
        pending_next = pending_reg;
        en_held      = 1'b0;
        en_char      = 1'b0;
        plain_path   = 1'b0;
        unique case (mode_reg)
            MODE_COMMENT: begin
                if (item.ch == CH_CR || item.ch == CH_LF) begin
                    en_char   = 1'b1;
                    mode_next = MODE_PLAIN;
                end
            end
            MODE_QUOTE: begin
                en_char = 1'b1;
                if (qc == quote_reg) begin
                    mode_next  = MODE_PLAIN;
                    quote_next = QK_NONE;
                end
            end
            default: begin
                plain_path = 1'b1;
                if (pending_reg) begin
                    pending_next = 1'b0;
                    if (item.ch == CH_STAR) begin
                        mode_next  = MODE_COMMENT;
                        plain_path = 1'b0;
                    end else begin
                        en_held = 1'b1;
                    end
                end
                if (plain_path) begin
                    if (item.ch == CH_SLASH) begin
                        pending_next = 1'b1;
                    end else begin
                        en_char = 1'b1;
                        if (qc != QK_NONE) begin
                            mode_next  = MODE_QUOTE;
                            quote_next = qc;
                        end
                    end
                end
            end
        endcase
    end

    // Only the scanned character can be a control code; the slash never is.
    assign is_control   = item.ch < CH_SPACE;
    assign en_char_kept = en_char && !(strip_controls && is_control);
    assign en_tail      = item.last && pending_next;
    assign n_res = {1'b0, en_held} + {1'b0, en_char_kept} + {1'b0, en_tail};

    always_comb begin
        r0.out_char    = en_held ? CH_SLASH : (en_char_kept ? item.ch : CH_SLASH);
        r0.has_char    = 1'b1;
        r0.end_of_text = item.last && (n_res == 2'd1);
        r1.out_char    = (en_held && en_char_kept) ? item.ch : CH_SLASH;
        r1.has_char    = 1'b1;
        r1.end_of_text = item.last;
        push.count     = take ? n_res : 2'd0;
        if (item.last && n_res == 2'd0) begin
            // Text ended with nothing to show: send a bare end marker.
            r0.out_char    = CH_NULL;
            r0.has_char    = 1'b0;
            r0.end_of_text = 1'b1;
            push.count     = take ? 2'd1 : 2'd0;
        end
        push.first  = r0;
        push.second = r1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_PLAIN;
            quote_reg   <= QK_NONE;
            pending_reg <= 1'b0;
        end else if (take) begin
            if (item.last) begin
                mode_reg    <= MODE_PLAIN;
                quote_reg   <= QK_NONE;
                pending_reg <= 1'b0;
            end else begin
                mode_reg    <= mode_next;
                quote_reg   <= quote_next;
                pending_reg <= pending_next;
            end
        end
    end

endmodule

@@ rtl/fcs_out_queue.sv @@
`timescale 1ns / 1ps
// ============================================================================
// fcs_out_queue - result queue
// Small ring buffer: takes one or two results, hands out one a cycle on m_ready.
// ============================================================================
module fcs_out_queue
    import fcs_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)(
    input  logic  aclk,
    input  logic  aresetn,
    input  push_t push,
    output logic  room,
    output logic  m_valid,
    input  logic  m_ready,
    output res_t  m_res
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(DEPTH - 1);
    localparam logic [PTR_W-1:0] PTR_ONE   = PTR_W'(1);
    localparam logic [CNT_W-1:0] ROOM_MAX  = CNT_W'(DEPTH - 2);

    res_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next, wr_ptr_plus1, wr_ptr_plus2;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             pop;

    assign room    = count_reg <= ROOM_MAX;
    assign m_valid = count_reg != '0;
    assign m_res   = mem[rd_ptr_reg];
    assign pop     = m_valid && m_ready;

    assign wr_ptr_plus1 = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_ONE;
    assign wr_ptr_plus2 = (wr_ptr_plus1 == PTR_LAST) ? '0 : wr_ptr_plus1 + PTR_ONE;

    always_comb begin
        unique case (push.count)
            2'd0:    wr_ptr_next = wr_ptr_reg;
            2'd1:    wr_ptr_next = wr_ptr_plus1;
            default: wr_ptr_next = wr_ptr_plus2;
        endcase
        rd_ptr_next = rd_ptr_reg;
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_ONE;
        end
        count_next = count_reg + CNT_W'(push.count) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2) begin
            mem[wr_ptr_plus1] <= push.second;
        end
    end

endmodule

@@ rtl/format_comment_stripper_core.sv @@
`timescale 1ns / 1ps
// ============================================================================
// format_comment_stripper_core - comment stripper for format-script text
// Drops slash-star comments up to the line end outside quotes and can
// remove control characters from what is left.
// ============================================================================
//
// Channel   Direction  Transaction carries
// --------  ---------  ---------------------------------------------------
// s_axis    in         tdata = ch, tlast = last (final character of a text)
// m_axis    out        tdata = out_char, tuser = has_char, tlast = end_of_text
// apb       in/out     register 0 (byte address 0): strip_controls, bit 0
//
// Flow: a character moves from the input register through the scanner into
// the result queue, so one character is taken per cycle while the queue has
// room. For a character that yields two results the output port sets the
// rate, at one result per cycle while m_axis_tready is high.
// Path: input register first, then the result queue that drives m_axis.
// Reset: aresetn is synchronous and active low; it empties the input register
// and the queue, returns the scanner to plain text and sets strip_controls.
// Stalls: input is taken while the queue has room for two results, so a held
// m_axis result stops the input side only once under two entries are free.
//
module format_comment_stripper_core
    import fcs_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [CHAR_W-1:0]     s_axis_tdata,   // [15:0] ch
    input  logic                  s_axis_tlast,

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [CHAR_W-1:0]     m_axis_tdata,   // [15:0] out_char
    output logic                  m_axis_tuser,   // [0] has_char
    output logic                  m_axis_tlast,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    // Configuration register. The upper address bit selects the register
    // index; the lower two bits are the byte offset inside the word.
    logic strip_controls_reg;
    logic reg_hit;

    assign pready  = 1'b1;
    assign reg_hit = paddr[APB_ADDR_W-1:2] == REG_STRIP_CONTROLS;
    assign prdata  = reg_hit ? {{(APB_DATA_W-1){1'b0}}, strip_controls_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            strip_controls_reg <= 1'b1;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            strip_controls_reg <= pwdata[0];
        end
    end

    // Datapath: input register, scanner, result queue.
    item_t s_item, item;
    logic  item_valid, take, room;
    push_t push;
    res_t  m_res;

    assign s_item.ch   = s_axis_tdata;
    assign s_item.last = s_axis_tlast;

    fcs_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_axis_tvalid),
        .s_ready    (s_axis_tready),
        .s_item     (s_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    fcs_scan u_scan (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .strip_controls (strip_controls_reg),
        .item_valid     (item_valid),
        .item           (item),
        .room           (room),
        .take           (take),
        .push           (push)
    );

    fcs_out_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_out_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .room    (room),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .m_res   (m_res)
    );

    assign m_axis_tdata = m_res.out_char;
    assign m_axis_tuser = m_res.has_char;
    assign m_axis_tlast = m_res.end_of_text;

endmodule

@@ rtl/fcs_checker.sv @@
`timescale 1ns / 1ps
// ============================================================================
// fcs_checker - port-level checks for the comment stripper
// Watches the stream ports over time; bound to the top level.
// ============================================================================
module fcs_checker
    import fcs_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_axis_tready,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [CHAR_W-1:0] m_axis_tdata,
    input logic              m_axis_tuser,
    input logic              m_axis_tlast
);

    // A stalled result stays put until taken.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // A bare marker only closes a text and carries no character.
    a_marker: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast && m_axis_tdata == CH_NULL)
        else $error("bare marker malformed");

    // Reset empties the result queue.
    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result pending after reset");

    // Reset empties the input register, so input is open right after.
    a_reset_in: assert property (@(posedge aclk)
        !aresetn |=> s_axis_tready)
        else $error("input not ready after reset");

endmodule

bind format_comment_stripper_core fcs_checker u_fcs_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

@@ tb/format_comment_stripper_core_tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// format_comment_stripper_core_tb - self-checking bench for the comment stripper
// Streams script texts through the core, predicts the cleaned character stream
// in step with every accepted character and checks each result transaction
// field by field, under both control-filter settings and random back-pressure.
// ============================================================================
module format_comment_stripper_core_tb;
    import fcs_pkg::*;

    localparam int HALF_PERIOD    = 4;
    localparam int RESET_CYCLES   = 11;
    localparam int IDLE_PERCENT   = 23;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_CHARS   = 190;

    typedef enum logic [1:0] {SCAN_PLAIN, SCAN_QUOTE, SCAN_COMMENT} scan_e;
    typedef enum logic [1:0] {QUOTE_NONE, QUOTE_APOS, QUOTE_DQUOTE, QUOTE_BAR} quote_e;

    logic                  aclk = 1'b0;
    logic                  aresetn;

    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [CHAR_W-1:0]     s_axis_tdata;   // [15:0] ch
    logic                  s_axis_tlast;

    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [CHAR_W-1:0]     m_axis_tdata;   // [15:0] out_char
    logic                  m_axis_tuser;   // [0] has_char
    logic                  m_axis_tlast;

    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Predictor state: scanner mode, open quote, held slash and the filter bit.
    scan_e  scan_state;
    quote_e open_quote;
    logic   slash_held;
    logic   strip_on;

    // Cleaned characters still owed by the core, oldest first.
    res_t        cleaned_q[$];
    logic [15:0] text_buf[$];

    logic idle_on;
    int   chars_sent;
    int   texts_sent;
    int   results_checked;
    int   errors;
    int   quiet_cycles;

    format_comment_stripper_core DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #HALF_PERIOD aclk = 1'b1;
        #HALF_PERIOD aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic quote_e quote_of(input logic [15:0] c);
        if (c == CH_APOS) return QUOTE_APOS;
        if (c == CH_DQUOTE) return QUOTE_DQUOTE;
        if (c == CH_BAR) return QUOTE_BAR;
        return QUOTE_NONE;
    endfunction

    // Handles a character in plain text. A slash is held back and not emitted;
    // a quote character opens a quote and is itself emitted.
    function automatic logic scan_plain(input logic [15:0] c);
        quote_e q;
        q = quote_of(c);
        if (c == CH_SLASH) begin
            slash_held = 1'b1;
            return 1'b0;
        end
        if (q != QUOTE_NONE) begin
            scan_state = SCAN_QUOTE;
            open_quote = q;
        end
        return 1'b1;
    endfunction

    // Advances the predictor by one accepted character and queues what the
    // core owes for it: the surviving characters, or a bare end marker.
    function automatic void strip_step(input logic [15:0] c, input logic last);
        logic [15:0] raw [0:1];
        res_t        kept [0:1];
        res_t        marker;
        int          nraw;
        int          nkept;
        nraw  = 0;
        nkept = 0;
        case (scan_state)
            SCAN_COMMENT: begin
                // Everything up to the line end is dropped; the CR or LF stays.
                if (c == CH_CR || c == CH_LF) begin
                    raw[nraw] = c;
                    nraw++;
                    scan_state = SCAN_PLAIN;
                end
            end
            SCAN_QUOTE: begin
                raw[nraw] = c;
                nraw++;
                if (quote_of(c) == open_quote) begin
                    scan_state = SCAN_PLAIN;
                    open_quote = QUOTE_NONE;
                end
            end
            default: begin
                if (slash_held) begin
                    slash_held = 1'b0;
                    if (c == CH_STAR) begin
                        scan_state = SCAN_COMMENT;
                    end else begin
                        raw[nraw] = CH_SLASH;
                        nraw++;
                        if (scan_plain(c)) begin
                            raw[nraw] = c;
                            nraw++;
                        end
                    end
                end else if (scan_plain(c)) begin
                    raw[nraw] = c;
                    nraw++;
                end
            end
        endcase

        // A slash still held at the end of the text goes out last.
        if (last && slash_held && nraw < 2) begin
            raw[nraw] = CH_SLASH;
            nraw++;
        end

        for (int i = 0; i < nraw; i++) begin
            if (!(strip_on && raw[i] < CH_SPACE)) begin
                kept[nkept].out_char    = raw[i];
                kept[nkept].has_char    = 1'b1;
                kept[nkept].end_of_text = 1'b0;
                nkept++;
            end
        end

        if (last) begin
            if (nkept == 0) begin
                marker.out_char    = CH_NULL;
                marker.has_char    = 1'b0;
                marker.end_of_text = 1'b1;
                kept[0] = marker;
                nkept   = 1;
            end else begin
                kept[nkept-1].end_of_text = 1'b1;
            end
            scan_state = SCAN_PLAIN;
            open_quote = QUOTE_NONE;
            slash_held = 1'b0;
        end

        for (int i = 0; i < nkept; i++)
            cleaned_q.insert(cleaned_q.size(), kept[i]);
    endfunction

    // ------------------------------------------------------------------------
    // Result checker, receiver stalls and watchdog
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : result_monitor
        res_t seen;
        res_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            seen.out_char    = m_axis_tdata;
            seen.has_char    = m_axis_tuser;
            seen.end_of_text = m_axis_tlast;
            results_checked++;
            if (cleaned_q.size() == 0) begin
                $error("unexpected result: out_char %h has_char %b end_of_text %b",
                       seen.out_char, seen.has_char, seen.end_of_text);
                errors++;
            end else begin
                want = cleaned_q.pop_front();
                if (seen.out_char !== want.out_char) begin
                    $error("out_char: expected %h, got %h", want.out_char, seen.out_char);
                    errors++;
                end
                if (seen.has_char !== want.has_char) begin
                    $error("has_char: expected %b, got %b", want.has_char, seen.has_char);
                    errors++;
                end
                if (seen.end_of_text !== want.end_of_text) begin
                    $error("end_of_text: expected %b, got %b",
                           want.end_of_text, seen.end_of_text);
                    errors++;
                end
            end
        end

        // The watchdog counts cycles in which neither channel moves a transaction.
        if (aresetn && ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("format_comment_stripper_core: mismatch");
            $finish;
        end else begin
            m_axis_tready <= !idle_on || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    // Appends one character to the text being built.
    function automatic void add_char(input logic [15:0] c);
        text_buf.insert(text_buf.size(), c);
    endfunction

    // Sends one character. Valid is lowered only for an idle gap, so a
    // back-to-back character keeps it high across the transaction.
    task automatic send_char(input logic [15:0] c, input logic last);
        while (idle_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= last;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        strip_step(c, last);
        chars_sent++;
    endtask

    task automatic send_text();
        for (int i = 0; i < text_buf.size(); i++)
            send_char(text_buf[i], i == text_buf.size() - 1);
        texts_sent++;
    endtask

    // Stops the sender and waits until every owed result has been taken, then
    // waits out a settle time for a character that owes nothing yet but may be in flight.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (cleaned_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Writes strip_controls, then reads it back in a second transaction.
    task automatic write_strip(input logic value);
        logic [APB_DATA_W-1:0] data;
        data    = $urandom();
        data[0] = value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_STRIP_CONTROLS, 2'b00};
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        strip_on = value;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (prdata[0] !== value) begin
            $error("strip_controls: expected %b, got %b", value, prdata[0]);
            errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [15:0] pick_quote();
        case ($urandom_range(0, 2))
            0:       return CH_APOS;
            1:       return CH_DQUOTE;
            default: return CH_BAR;
        endcase
    endfunction

    function automatic logic [15:0] noise_char();
        case ($urandom_range(0, 7))
            0:       return CH_SLASH;
            1:       return CH_STAR;
            2:       return pick_quote();
            3:       return $urandom_range(0, 1) ? CH_CR : CH_LF;
            4:       return 16'($urandom_range(0, 31));
            5:       return 16'($urandom_range(0, 16'hFFFF));
            default: return 16'($urandom_range(16'h20, 16'h7E));
        endcase
    endfunction

    // Appends one piece of well-formed script text with random content.
    task automatic add_segment();
        logic [15:0] q;
        int          n;
        case ($urandom_range(0, 9))
            0, 1: begin
                n = $urandom_range(1, 4);
                repeat (n) add_char(16'($urandom_range(16'h61, 16'h7A)));
            end
            2, 3: begin
                q = pick_quote();
                add_char(q);
                n = $urandom_range(0, 3);
                repeat (n) add_char(noise_char());
                add_char(q);
            end
            4, 5: begin
                add_char(CH_SLASH);
                add_char(CH_STAR);
                n = $urandom_range(0, 3);
                repeat (n) add_char(noise_char());
                add_char($urandom_range(0, 1) ? CH_CR : CH_LF);
            end
            6: begin
                add_char(CH_SLASH);
                add_char($urandom_range(0, 1) ? CH_SPACE : pick_quote());
            end
            7: begin
                n = $urandom_range(1, 2);
                repeat (n) add_char(16'($urandom_range(0, 31)));
            end
            8: begin
                add_char($urandom_range(0, 1) ? CH_SPACE
                         : 16'($urandom_range(16'h80, 16'hFFFF)));
            end
            default: begin
                // A slash, or a comment opener, that may run to the end of the text.
                add_char(CH_SLASH);
                if ($urandom_range(0, 1)) add_char(CH_STAR);
            end
        endcase
    endtask

    // Random texts: mostly well-formed segments, a quarter pure noise.
    task automatic run_random_texts(input int n_chars, input logic pause_midway);
        int start;
        int target;
        logic paused;
        start  = chars_sent;
        paused = 1'b0;
        while (chars_sent - start < n_chars) begin
            text_buf.delete();
            if ($urandom_range(0, 3) == 0) begin
                target = $urandom_range(1, 8);
                repeat (target) add_char(noise_char());
            end else begin
                target = $urandom_range(1, 12);
                while (text_buf.size() < target) add_segment();
            end
            send_text();
            if (pause_midway && !paused && chars_sent - start >= n_chars / 2) begin
                drain_results();
                paused = 1'b1;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Comment, quote and held-slash handling with the reset filter setting.
    task automatic test_comment_syntax();
        text_buf = '{16'h0001, CH_SLASH, CH_STAR, CH_LF, 16'h0061};
        send_text();
        text_buf = '{CH_APOS, CH_SLASH, CH_STAR, CH_APOS};
        send_text();
        text_buf = '{CH_SLASH};
        send_text();
        text_buf = '{CH_SLASH, 16'hFFFF};
        send_text();
        text_buf = '{CH_SLASH, CH_STAR, CH_NULL};
        send_text();
        drain_results();
    endtask

    // Control characters kept; other quote kinds and a CR ending a comment.
    task automatic test_controls_kept();
        write_strip(1'b0);
        text_buf = '{CH_DQUOTE, CH_BAR, CH_SLASH, CH_STAR, CH_DQUOTE};
        send_text();
        text_buf = '{CH_BAR, CH_BAR, CH_SLASH, CH_STAR, CH_CR};
        send_text();
        text_buf = '{CH_SLASH, CH_SLASH, 16'h001F};
        send_text();
        drain_results();
    endtask

    task automatic test_random_strip_off();
        run_random_texts(RANDOM_CHARS, 1'b1);
        drain_results();
    endtask

    task automatic test_random_strip_on();
        write_strip(1'b1);
        run_random_texts(RANDOM_CHARS, 1'b0);
        drain_results();
    endtask

    // Full-rate stretch: neither side idles.
    task automatic test_random_full_rate();
        write_strip(1'b0);
        idle_on = 1'b0;
        run_random_texts(RANDOM_CHARS, 1'b0);
        drain_results();
        idle_on = 1'b1;
    endtask

    initial begin
        aresetn       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        scan_state      = SCAN_PLAIN;
        open_quote      = QUOTE_NONE;
        slash_held      = 1'b0;
        strip_on        = 1'b1;
        idle_on         = 1'b1;
        chars_sent      = 0;
        texts_sent      = 0;
        results_checked = 0;
        errors          = 0;
        quiet_cycles    = 0;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_comment_syntax();
        test_controls_kept();
        test_random_strip_off();
        test_random_strip_on();
        test_random_full_rate();

        $display("Sent %0d texts (%0d characters) and checked %0d results,",
                 texts_sent, chars_sent, results_checked);
        $display("with the control filter off and on, under random and no back-pressure.");
        if (errors == 0) begin
            $display("format_comment_stripper_core: match");
        end else begin
            $display("format_comment_stripper_core: mismatch");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/fcs_pkg.sv
rtl/fcs_in_stage.sv
rtl/fcs_scan.sv
rtl/fcs_out_queue.sv
rtl/format_comment_stripper_core.sv
rtl/fcs_checker.sv
tb/format_comment_stripper_core_tb.sv
